>>> src/wrp_pkg.sv
// Package for the WAV RIFF header parser: phase and sequencer codes,
// status codes, chunk tags and format defaults.
// No dependencies.
`default_nettype none

package wrp_pkg;

   // Chunk and form tags, first byte in the top octet
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   // Format defaults when the file carries no fmt chunk
   localparam logic [15:0] DEF_CHANNELS = 16'd1;
   localparam logic [31:0] DEF_RATE     = 32'd22050;
   localparam logic [15:0] DEF_BITS     = 16'd1;
   localparam logic [15:0] DEF_ALIGN    = 16'd0;
   localparam logic [15:0] FMT_PCM      = 16'd1;

   // Result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_RIFF  = 3'd1;
   localparam logic [2:0] ST_SHORT_HDR = 3'd2;
   localparam logic [2:0] ST_BAD_FMT   = 3'd3;
   localparam logic [2:0] ST_SHORT_FMT = 3'd4;
   localparam logic [2:0] ST_NOT_PCM   = 3'd5;
   localparam logic [2:0] ST_BAD_RATE  = 3'd6;
   localparam logic [2:0] ST_NO_FMT    = 3'd7;

   // Where the parser stands in the file
   typedef enum logic [1:0] {
      PH_FILE,
      PH_CHDR,
      PH_FMT,
      PH_SKIP
   } phase_type;

   // Per-byte sequencer steps
   typedef enum logic [3:0] {
      SQ_IDLE,
      SQ_PARSE,
      SQ_RCMP,
      SQ_CEND,
      SQ_RATE1,
      SQ_RATE2,
      SQ_CHECK,
      SQ_DONE,
      SQ_EMIT
   } seq_type;

endpackage

`default_nettype wire

>>> src/wrp_stream_if.sv
// Valid/ready channel interfaces for the parser: file bytes in, results out.
// No dependencies.
`default_nettype none

interface wrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       end_of_file;

   modport source (output valid, output file_byte, output end_of_file, input ready);
   modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface wrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] channel_count;
   logic [31:0] sample_rate;
   logic [15:0] bits_per_sample;
   logic [15:0] frame_bytes;
   logic [31:0] data_start;
   logic [31:0] data_length;

   modport source (output valid, output status, output channel_count, output sample_rate,
                   output bits_per_sample, output frame_bytes, output data_start,
                   output data_length, input ready);
   modport sink   (input valid, input status, input channel_count, input sample_rate,
                   input bits_per_sample, input frame_bytes, input data_start,
                   input data_length, output ready);
endinterface

`default_nettype wire

>>> src/wrp_mul_unit.sv
// Shared multiplier for the byte-rate check: registered low 32 bits of
// a 32 x 16 product. No dependencies.
`default_nettype none

module wrp_mul_unit (
   input  wire logic        clock,
   input  wire logic        load,
   input  wire logic [31:0] op_a,
   input  wire logic [15:0] op_b,
   output logic      [31:0] prod
);

   logic [47:0] full_prod;
   logic [31:0] prod_ff;
   logic [31:0] prod_in;

   // product wraps at 32 bits
   assign full_prod = op_a * op_b;
   assign prod_in   = load ? full_prod[31:0] : prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

>>> src/wav_riff_header_parser_core.sv
// Top level of the WAV RIFF header parser.
// Depends on wrp_pkg, wrp_stream_if.sv and wrp_mul_unit.
`default_nettype none

// Byte-serial RIFF/WAVE header parser. Takes one file byte per transfer on
// req_ch and gives at most one result per file on rsp_ch: a status and the
// PCM format fields, plus the offset and size of the last data chunk. A small
// sequencer handles each byte and the block is not ready while it works:
// an ordinary byte is accepted, then parsed; the last byte of the file
// header adds the RIFF end compare, the last byte of a chunk header the
// 33-bit chunk end add and, unless it opens a fmt chunk, the end compares,
// and the last byte of the fmt body the byte-rate product, which goes twice
// through the one shared 32 x 16 multiplier. A failed check skips the steps
// that remain. Issuing a result is one more step, and waits while an earlier
// result still sits in the output register. After end_of_file the parser
// rearms for the next file; bytes that follow a settled result are accepted
// without a parse step and dropped.

module wav_riff_header_parser_core
   import wrp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   wrp_req_if.sink    req_ch,
   wrp_rsp_if.source  rsp_ch
);

   // parser state
   logic [32:0]     offset_ff, offset_in;
   logic [32:0]     riff_end_ff, riff_end_in;
   phase_type       phase_ff, phase_in;
   logic [3:0]      count_ff, count_in;
   logic [31:0]     tag_ff, tag_in;
   logic [3:0][7:0] size_ff, size_in;
   logic [32:0]     chunk_end_ff, chunk_end_in;
   logic            fmt_seen_ff, fmt_seen_in;
   logic [15:0][7:0] fmt_ff, fmt_in;
   logic [31:0]     data_start_ff, data_start_in;
   logic [31:0]     data_len_ff, data_len_in;
   logic            given_ff, given_in;

   // sequencer and latched transfer
   seq_type         seq_ff, seq_in;
   logic [7:0]      byte_ff, byte_in;
   logic            eof_ff, eof_in;
   logic [2:0]      status_ff, status_in;
   logic            clear_file;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      o_status_ff, o_status_in;
   logic [15:0]     o_chan_ff, o_chan_in;
   logic [31:0]     o_rate_ff, o_rate_in;
   logic [15:0]     o_bits_ff, o_bits_in;
   logic [15:0]     o_align_ff, o_align_in;
   logic [31:0]     o_dstart_ff, o_dstart_in;
   logic [31:0]     o_dlen_ff, o_dlen_in;

   // shared multiplier
   logic            mul_load;
   logic [31:0]     mul_a;
   logic [15:0]     mul_b;
   logic [31:0]     mul_prod;

   // fmt body fields, little endian
   logic [15:0] f_tag, f_chan, f_align, f_bits;
   logic [31:0] f_rate, f_brate;

   assign f_tag   = {fmt_ff[1], fmt_ff[0]};
   assign f_chan  = {fmt_ff[3], fmt_ff[2]};
   assign f_rate  = {fmt_ff[7], fmt_ff[6], fmt_ff[5], fmt_ff[4]};
   assign f_brate = {fmt_ff[11], fmt_ff[10], fmt_ff[9], fmt_ff[8]};
   assign f_align = {fmt_ff[13], fmt_ff[12]};
   assign f_bits  = {fmt_ff[15], fmt_ff[14]};

   // rate * bits first, then times channels
   assign mul_a = (seq_ff == SQ_RATE2) ? mul_prod : f_rate;
   assign mul_b = (seq_ff == SQ_RATE2) ? f_chan : f_bits;

   wrp_mul_unit u_mul (
      .clock (clock),
      .load  (mul_load),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   assign req_ch.ready = (seq_ff == SQ_IDLE);

   // sequencer: next state and parser updates
   always_comb begin
      offset_in     = offset_ff;
      riff_end_in   = riff_end_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      tag_in        = tag_ff;
      size_in       = size_ff;
      chunk_end_in  = chunk_end_ff;
      fmt_seen_in   = fmt_seen_ff;
      fmt_in        = fmt_ff;
      data_start_in = data_start_ff;
      data_len_in   = data_len_ff;
      given_in      = given_ff;
      seq_in        = seq_ff;
      byte_in       = byte_ff;
      eof_in        = eof_ff;
      status_in     = status_ff;
      clear_file    = 1'b0;
      mul_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      o_status_in   = o_status_ff;
      o_chan_in     = o_chan_ff;
      o_rate_in     = o_rate_ff;
      o_bits_in     = o_bits_ff;
      o_align_in    = o_align_ff;
      o_dstart_in   = o_dstart_ff;
      o_dlen_in     = o_dlen_ff;

      case (seq_ff)
         SQ_IDLE: begin
            if (req_ch.valid) begin
               byte_in = req_ch.file_byte;
               eof_in  = req_ch.end_of_file;
               if (given_ff) begin
                  // result already out: drop the byte, rearm at end of file
                  clear_file = req_ch.end_of_file;
               end else begin
                  offset_in = offset_ff + 33'd1;
                  seq_in    = SQ_PARSE;
               end
            end
         end

         SQ_PARSE: begin
            case (phase_ff)
               PH_FILE: begin
                  if (count_ff[3:2] != 2'b01) begin
                     tag_in = {tag_ff[23:0], byte_ff};
                  end else begin
                     if (count_ff == 4'd4) size_in = '0;
                     size_in[count_ff[1:0]] = byte_ff;
                  end
                  if (count_ff == 4'd3 && tag_in != TAG_RIFF) begin
                     status_in = ST_BAD_RIFF;
                     seq_in    = SQ_EMIT;
                  end else if (count_ff == 4'd11) begin
                     if (tag_in != TAG_WAVE) begin
                        status_in = ST_BAD_RIFF;
                        seq_in    = SQ_EMIT;
                     end else begin
                        riff_end_in = {1'b0, size_ff} + 33'd8;
                        seq_in      = SQ_RCMP;
                     end
                  end else begin
                     count_in = count_ff + 4'd1;
                     if (eof_ff) begin
                        status_in = ST_BAD_RIFF;
                        seq_in    = SQ_EMIT;
                     end else begin
                        seq_in = SQ_IDLE;
                     end
                  end
               end

               PH_CHDR: begin
                  if (count_ff[3:2] == 2'b00) begin
                     tag_in = {tag_ff[23:0], byte_ff};
                  end else begin
                     if (count_ff == 4'd4) size_in = '0;
                     size_in[count_ff[1:0]] = byte_ff;
                  end
                  if (count_ff != 4'd7) begin
                     count_in = count_ff + 4'd1;
                     if (eof_ff) begin
                        status_in = ST_SHORT_HDR;
                        seq_in    = SQ_EMIT;
                     end else begin
                        seq_in = SQ_IDLE;
                     end
                  end else begin
                     seq_in = SQ_CEND;
                  end
               end

               PH_FMT: begin
                  fmt_in[count_ff] = byte_ff;
                  if (count_ff != 4'd15) begin
                     count_in = count_ff + 4'd1;
                     if (eof_ff) begin
                        status_in = ST_SHORT_FMT;
                        seq_in    = SQ_EMIT;
                     end else begin
                        seq_in = SQ_IDLE;
                     end
                  end else begin
                     seq_in = SQ_RATE1;
                  end
               end

               default: begin
                  // skipping a chunk body
                  if (eof_ff) begin
                     status_in = ST_OK;
                     seq_in    = SQ_EMIT;
                  end else begin
                     if (offset_ff >= chunk_end_ff) begin
                        phase_in = PH_CHDR;
                        count_in = '0;
                     end
                     seq_in = SQ_IDLE;
                  end
               end
            endcase
         end

         // file header done: stop if the RIFF body is already used up or the file ended
         SQ_RCMP: begin
            if (offset_ff >= riff_end_ff || eof_ff) begin
               status_in = ST_OK;
               seq_in    = SQ_EMIT;
            end else begin
               phase_in = PH_CHDR;
               count_in = '0;
               seq_in   = SQ_IDLE;
            end
         end

         // chunk header done: chunk end and tag decisions
         SQ_CEND: begin
            chunk_end_in = offset_ff + {1'b0, size_ff};
            if (tag_ff == TAG_FMT) begin
               if (fmt_seen_ff || size_ff < 32'd16) begin
                  status_in = ST_BAD_FMT;
                  seq_in    = SQ_EMIT;
               end else begin
                  fmt_seen_in = 1'b1;
                  phase_in    = PH_FMT;
                  count_in    = '0;
                  if (eof_ff) begin
                     status_in = ST_SHORT_FMT;
                     seq_in    = SQ_EMIT;
                  end else begin
                     seq_in = SQ_IDLE;
                  end
               end
            end else if (tag_ff == TAG_DATA && !fmt_seen_ff) begin
               status_in = ST_NO_FMT;
               seq_in    = SQ_EMIT;
            end else begin
               if (tag_ff == TAG_DATA) begin
                  data_start_in = offset_ff[31:0];
                  data_len_in   = size_ff;
               end
               seq_in = SQ_DONE;
            end
         end

         // fmt body done: format tag, then rate * bits
         SQ_RATE1: begin
            if (f_tag != FMT_PCM) begin
               status_in = ST_NOT_PCM;
               seq_in    = SQ_EMIT;
            end else begin
               mul_load = 1'b1;
               seq_in   = SQ_RATE2;
            end
         end

         SQ_RATE2: begin
            mul_load = 1'b1;
            seq_in   = SQ_CHECK;
         end

         // byte rate must be the wrapped product over 8, and bits 8, 16 or 32
         SQ_CHECK: begin
            if ({3'b000, mul_prod[31:3]} != f_brate ||
                !(f_bits inside {16'd8, 16'd16, 16'd32})) begin
               status_in = ST_BAD_RATE;
               seq_in    = SQ_EMIT;
            end else begin
               seq_in = SQ_DONE;
            end
         end

         // end of a chunk header or fmt body
         SQ_DONE: begin
            if (chunk_end_ff >= riff_end_ff || eof_ff) begin
               status_in = ST_OK;
               seq_in    = SQ_EMIT;
            end else begin
               count_in = '0;
               phase_in = (chunk_end_ff == offset_ff) ? PH_CHDR : PH_SKIP;
               seq_in   = SQ_IDLE;
            end
         end

         // load the output register once it is free
         SQ_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               o_status_in  = status_ff;
               o_chan_in    = '0;
               o_rate_in    = '0;
               o_bits_in    = '0;
               o_align_in   = '0;
               o_dstart_in  = '0;
               o_dlen_in    = '0;
               if (status_ff == ST_OK) begin
                  o_chan_in   = fmt_seen_ff ? f_chan  : DEF_CHANNELS;
                  o_rate_in   = fmt_seen_ff ? f_rate  : DEF_RATE;
                  o_bits_in   = fmt_seen_ff ? f_bits  : DEF_BITS;
                  o_align_in  = fmt_seen_ff ? f_align : DEF_ALIGN;
                  o_dstart_in = data_start_ff;
                  o_dlen_in   = data_len_ff;
               end
               given_in = 1'b1;
               seq_in   = SQ_IDLE;
            end
         end

         default: begin
            seq_in = SQ_IDLE;
         end
      endcase

      // byte finished with end of file: back to the file header
      if (seq_ff != SQ_IDLE && seq_in == SQ_IDLE && eof_ff) clear_file = 1'b1;

      if (clear_file) begin
         offset_in     = '0;
         riff_end_in   = '0;
         phase_in      = PH_FILE;
         count_in      = '0;
         tag_in        = '0;
         size_in       = '0;
         chunk_end_in  = '0;
         fmt_seen_in   = 1'b0;
         fmt_in        = '0;
         data_start_in = '0;
         data_len_in   = '0;
         given_in      = 1'b0;
      end
   end

   // control and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= '0;
         riff_end_ff   <= '0;
         phase_ff      <= PH_FILE;
         count_ff      <= '0;
         tag_ff        <= '0;
         size_ff       <= '0;
         chunk_end_ff  <= '0;
         fmt_seen_ff   <= 1'b0;
         fmt_ff        <= '0;
         data_start_ff <= '0;
         data_len_ff   <= '0;
         given_ff      <= 1'b0;
         seq_ff        <= SQ_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         offset_ff     <= offset_in;
         riff_end_ff   <= riff_end_in;
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         tag_ff        <= tag_in;
         size_ff       <= size_in;
         chunk_end_ff  <= chunk_end_in;
         fmt_seen_ff   <= fmt_seen_in;
         fmt_ff        <= fmt_in;
         data_start_ff <= data_start_in;
         data_len_ff   <= data_len_in;
         given_ff      <= given_in;
         seq_ff        <= seq_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      eof_ff      <= eof_in;
      status_ff   <= status_in;
      o_status_ff <= o_status_in;
      o_chan_ff   <= o_chan_in;
      o_rate_ff   <= o_rate_in;
      o_bits_ff   <= o_bits_in;
      o_align_ff  <= o_align_in;
      o_dstart_ff <= o_dstart_in;
      o_dlen_ff   <= o_dlen_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = o_status_ff;
   assign rsp_ch.channel_count   = o_chan_ff;
   assign rsp_ch.sample_rate     = o_rate_ff;
   assign rsp_ch.bits_per_sample = o_bits_ff;
   assign rsp_ch.frame_bytes     = o_align_ff;
   assign rsp_ch.data_start      = o_dstart_ff;
   assign rsp_ch.data_length     = o_dlen_ff;

endmodule

`default_nettype wire
